@@ src/ffsi_pkg.sv @@
// shared types, widths and codes for the flat face shading block
package ffsi_pkg;

  localparam int COORD_BITS      = 24;
  localparam int LIGHT_BITS      = 16;
  localparam int LIGHT_FRAC_BITS = 14;
  localparam int SHADE_BITS      = 8;

  localparam int DIFF_W  = COORD_BITS + 1;          // edge vector component
  localparam int MULA_W  = DIFF_W + 1;              // signed operand of the shared multiplier
  localparam int PRODA_W = 2 * MULA_W;
  localparam int NRM_W   = 2 * DIFF_W + 1;          // normal component, signed
  localparam int MAG_W   = NRM_W - 1;               // normal magnitude, two pieces of DIFF_W
  localparam int PRODB_W = NRM_W + LIGHT_BITS;
  localparam int DOT_W   = PRODB_W + 2;
  localparam int SQ_W    = 2 * MAG_W + 2;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int NUM_W   = DOT_W + SHADE_BITS;
  localparam int DEN_W   = ROOT_W + LIGHT_FRAC_BITS;
  localparam int DSH_W   = DEN_W + SHADE_BITS;
  localparam int SH_W    = $clog2(SQ_W);
  localparam int STEP_W  = $clog2(ROOT_W);

  localparam int CROSS_LAST = 6;
  localparam int DOT_LAST   = 3;
  localparam int SQ_LAST    = 9;
  localparam int ROOT_LAST  = ROOT_W - 1;
  localparam int DIV_LAST   = SHADE_BITS + 1;

  localparam logic [1:0] SLOT_LAST = 2'd2;

  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  localparam logic signed [LIGHT_BITS-1:0] LIGHT_X_RST = -16'sd7327;
  localparam logic signed [LIGHT_BITS-1:0] LIGHT_Y_RST = 16'sd0;
  localparam logic signed [LIGHT_BITS-1:0] LIGHT_Z_RST = 16'sd14654;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CROSS, ST_CHECK, ST_DOT, ST_SQ, ST_ROOT, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_CROSS, OP_DOT, OP_SQ, OP_ROOT, OP_DIV
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic              wr_vert;
    logic [1:0]        slot;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
  } stat_t;

endpackage

@@ src/ffsi_ctrl.sv @@
// controller: vertex slot counter, step counter and sequencing of the face math
module ffsi_ctrl import ffsi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  vert_valid,
  output logic  vert_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [1:0]        corner_slot, corner_slot_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      corner_slot <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      corner_slot <= corner_slot_next;
      out_valid   <= out_valid_next;
    end
  end

  always_comb begin
    state_next       = state;
    step_next        = step + 1'b1;
    corner_slot_next = corner_slot;
    vert_ready       = 1'b0;
    cmd.op           = OP_NONE;
    cmd.step         = step;
    cmd.wr_vert      = 1'b0;
    cmd.slot         = corner_slot;
    cmd.load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        vert_ready = 1'b1;
        step_next  = '0;
        if (vert_valid) begin
          cmd.wr_vert = 1'b1;
          if (corner_slot == SLOT_LAST) begin
            corner_slot_next = '0;
            state_next       = ST_CROSS;
          end else begin
            corner_slot_next = corner_slot + 1'b1;
          end
        end
      end
      ST_CROSS: begin
        cmd.op = OP_CROSS;
        if (step == STEP_W'(CROSS_LAST)) begin
          step_next  = '0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        step_next  = '0;
        state_next = stat.n_zero ? ST_DONE : ST_DOT;
      end
      ST_DOT: begin
        cmd.op = OP_DOT;
        if (step == STEP_W'(DOT_LAST)) begin
          step_next  = '0;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op = OP_SQ;
        if (step == STEP_W'(SQ_LAST)) begin
          step_next  = '0;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.op = OP_ROOT;
        if (step == STEP_W'(ROOT_LAST)) begin
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (step == STEP_W'(DIV_LAST)) begin
          step_next  = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        step_next = '0;
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

@@ src/ffsi_datapath.sv @@
// datapath: corner store, light registers, multipliers, root and divide
module ffsi_datapath import ffsi_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic signed [COORD_BITS-1:0]  vert_x,
  input  logic signed [COORD_BITS-1:0]  vert_y,
  input  logic signed [COORD_BITS-1:0]  vert_z,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [LIGHT_BITS-1:0]         cfg_data,
  output logic [SHADE_BITS-1:0]         shade,
  output logic                          degenerate
);

  logic signed [COORD_BITS-1:0] corner_x [3];
  logic signed [COORD_BITS-1:0] corner_y [3];
  logic signed [COORD_BITS-1:0] corner_z [3];
  logic signed [LIGHT_BITS-1:0] light [3];

  logic signed [DIFF_W-1:0]  ea [3];
  logic signed [DIFF_W-1:0]  eb [3];
  logic signed [NRM_W-1:0]   n [3];
  logic        [MAG_W-1:0]   mag [3];
  logic        [1:0]         sq_idx;
  logic signed [MULA_W-1:0]  mula_x, mula_y;
  logic signed [PRODA_W-1:0] prod_a;
  logic        [SH_W-1:0]    sh_sel, prod_sh;
  logic signed [NRM_W-1:0]   mulb_n;
  logic signed [LIGHT_BITS-1:0] mulb_l;
  logic signed [PRODB_W-1:0] prod_b;
  logic signed [DOT_W-1:0]   dot;
  logic        [DOT_W-1:0]   dot_mag;
  logic        [NUM_W-1:0]   num;
  logic        [SQ_W-1:0]    acc, sqv, sq_src;
  logic        [REM_W-1:0]   rem, rem_in, r2, trial;
  logic        [ROOT_W-1:0]  root, root_in;
  logic        [NUM_W-1:0]   rem_d;
  logic        [DSH_W-1:0]   dsh, dsh_sh;
  logic        [SHADE_BITS-1:0] q;
  logic                      sat;

  always_ff @(posedge clk) begin
    if (cmd.wr_vert) begin
      corner_x[cmd.slot] <= vert_x;
      corner_y[cmd.slot] <= vert_y;
      corner_z[cmd.slot] <= vert_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= LIGHT_X_RST;
      light[1] <= LIGHT_Y_RST;
      light[2] <= LIGHT_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_X: light[0] <= cfg_data;
        REG_LIGHT_Y: light[1] <= cfg_data;
        REG_LIGHT_Z: light[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ea[0] = DIFF_W'(corner_x[1]) - DIFF_W'(corner_x[0]);
    ea[1] = DIFF_W'(corner_y[1]) - DIFF_W'(corner_y[0]);
    ea[2] = DIFF_W'(corner_z[1]) - DIFF_W'(corner_z[0]);
    eb[0] = DIFF_W'(corner_x[2]) - DIFF_W'(corner_x[0]);
    eb[1] = DIFF_W'(corner_y[2]) - DIFF_W'(corner_y[0]);
    eb[2] = DIFF_W'(corner_z[2]) - DIFF_W'(corner_z[0]);
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i][NRM_W-1] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
    end
  end

  assign stat.n_zero = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);

  // shared multiplier: cross terms, then pieces of the squared magnitudes
  always_comb begin
    mula_x = '0;
    mula_y = '0;
    sh_sel = '0;
    case (cmd.step)
      0, 1, 2: sq_idx = 2'd0;
      3, 4, 5: sq_idx = 2'd1;
      default: sq_idx = 2'd2;
    endcase
    if (cmd.op == OP_CROSS) begin
      case (cmd.step)
        0: begin mula_x = MULA_W'(ea[1]); mula_y = MULA_W'(eb[2]); end
        1: begin mula_x = MULA_W'(ea[2]); mula_y = MULA_W'(eb[1]); end
        2: begin mula_x = MULA_W'(ea[2]); mula_y = MULA_W'(eb[0]); end
        3: begin mula_x = MULA_W'(ea[0]); mula_y = MULA_W'(eb[2]); end
        4: begin mula_x = MULA_W'(ea[0]); mula_y = MULA_W'(eb[1]); end
        5: begin mula_x = MULA_W'(ea[1]); mula_y = MULA_W'(eb[0]); end
        default: ;
      endcase
    end else if (cmd.op == OP_SQ) begin
      case (cmd.step)
        0, 3, 6: begin
          mula_x = {1'b0, mag[sq_idx][MAG_W-1:DIFF_W]};
          mula_y = mula_x;
          sh_sel = SH_W'(2 * DIFF_W);
        end
        1, 4, 7: begin
          mula_x = {1'b0, mag[sq_idx][MAG_W-1:DIFF_W]};
          mula_y = {1'b0, mag[sq_idx][DIFF_W-1:0]};
          sh_sel = SH_W'(DIFF_W + 1);
        end
        2, 5, 8: begin
          mula_x = {1'b0, mag[sq_idx][DIFF_W-1:0]};
          mula_y = mula_x;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mulb_n = '0;
    mulb_l = '0;
    case (cmd.step)
      0: begin mulb_n = n[0]; mulb_l = light[0]; end
      1: begin mulb_n = n[1]; mulb_l = light[1]; end
      2: begin mulb_n = n[2]; mulb_l = light[2]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_a  <= mula_x * mula_y;
    prod_sh <= sh_sel;
    prod_b  <= mulb_n * mulb_l;
  end

  // the registered product of the previous step is folded in
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CROSS) begin
      case (cmd.step)
        1: n[0] <= NRM_W'(prod_a);
        2: n[0] <= n[0] - NRM_W'(prod_a);
        3: n[1] <= NRM_W'(prod_a);
        4: n[1] <= n[1] - NRM_W'(prod_a);
        5: n[2] <= NRM_W'(prod_a);
        6: n[2] <= n[2] - NRM_W'(prod_a);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DOT) begin
      if (cmd.step == '0) dot <= '0;
      else dot <= dot + DOT_W'(prod_b);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ) begin
      if (cmd.step == '0) acc <= '0;
      else acc <= acc + (SQ_W'(prod_a) << prod_sh);
    end
  end

  // integer square root, two radicand bits a step
  always_comb begin
    sq_src  = (cmd.step == '0) ? acc : sqv;
    rem_in  = (cmd.step == '0) ? '0 : rem;
    root_in = (cmd.step == '0) ? '0 : root;
    r2      = {rem_in[REM_W-3:0], sq_src[SQ_W-1:SQ_W-2]};
    trial   = REM_W'({root_in, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROOT) begin
      sqv <= sq_src << 2;
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // restoring divide of 255*|dot| by root*2^frac, saturating at full scale
  always_comb begin
    dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    num     = (NUM_W'(dot_mag) << SHADE_BITS) - NUM_W'(dot_mag);
    dsh_sh  = dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV) begin
      case (cmd.step)
        0: begin
          rem_d <= num;
          dsh   <= DSH_W'(root) << (LIGHT_FRAC_BITS + SHADE_BITS);
          q     <= '0;
          sat   <= 1'b0;
        end
        1: sat <= rem_d >= NUM_W'(dsh);
        default: begin
          dsh <= dsh_sh;
          if (rem_d >= NUM_W'(dsh_sh)) begin
            rem_d <= rem_d - NUM_W'(dsh_sh);
            q     <= {q[SHADE_BITS-2:0], 1'b1};
          end else begin
            q     <= {q[SHADE_BITS-2:0], 1'b0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      degenerate <= stat.n_zero;
      if (stat.n_zero) shade <= '0;
      else if (sat) shade <= '1;
      else shade <= q;
    end
  end

endmodule

@@ src/flat_face_shade_intensity.sv @@
// top level of the flat face shading block
// Takes one vertex (signed Q7.16 x, y, z) per beat on the vert channel and
// keeps the last three in a corner store filled slot 0, 1, 2 in turn.
// The beat that fills slot 2 closes a triangle: the block forms the face
// normal, its length and the dot product with the light direction, and
// puts one beat on the out channel: shade = min(255, 255*|cos|) and a
// degenerate flag (shade 0) when the normal is zero.
// While idle, the block takes the first two vertices of a triangle as they
// are offered. The third starts the work: the cross product, a test for a
// zero normal, the dot product, the squared length, the square root (one
// result bit a cycle), the divide (one shade bit a cycle), then a load of
// the output register. A degenerate face skips straight to the output after
// the zero test. No vertex is taken during that work. The result sits in an
// output register, so while the receiver stalls the block keeps taking
// vertices and finishes the next face, then holds it until the waiting beat
// leaves. Light registers are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// Reset clears the slot counter and the output valid and loads the default
// light direction; the corner store is not cleared.
module flat_face_shade_intensity import ffsi_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         vert_valid,
  output logic                         vert_ready,
  input  logic signed [COORD_BITS-1:0] vert_x,
  input  logic signed [COORD_BITS-1:0] vert_y,
  input  logic signed [COORD_BITS-1:0] vert_z,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [LIGHT_BITS-1:0]        cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SHADE_BITS-1:0]        shade,
  output logic                         degenerate
);

  cmd_t  cmd;
  stat_t stat;

  ffsi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .vert_valid (vert_valid),
    .vert_ready (vert_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ffsi_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .vert_x     (vert_x),
    .vert_y     (vert_y),
    .vert_z     (vert_z),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .shade      (shade),
    .degenerate (degenerate)
  );

  a_degen_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> shade == '0)
    else $error("degenerate face with nonzero shade");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(vert_ready))
    else $error("result loaded while taking vertices");

  a_load_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !vert_ready && !cmd.wr_vert)
    else $error("output load overlaps a vertex write");

endmodule

@@ bench/ffsi_checker.sv @@
// checker for the flat face shading block: watches the channels, predicts and compares
`timescale 1ns / 1ps
module ffsi_checker import ffsi_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         vert_valid,
  input  logic                         vert_ready,
  input  logic signed [COORD_BITS-1:0] vert_x,
  input  logic signed [COORD_BITS-1:0] vert_y,
  input  logic signed [COORD_BITS-1:0] vert_z,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [LIGHT_BITS-1:0]        cfg_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [SHADE_BITS-1:0]        shade,
  input  logic                         degenerate,
  output int                           fail_count,
  output int                           pending
);

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic [SHADE_BITS-1:0] shade;
    logic                  degenerate;
  } face_shade_t;

  logic signed [COORD_BITS-1:0] corner_x [3];
  logic signed [COORD_BITS-1:0] corner_y [3];
  logic signed [COORD_BITS-1:0] corner_z [3];
  logic [1:0]                   corner_slot;
  logic signed [LIGHT_BITS-1:0] light_x, light_y, light_z;
  face_shade_t                  shade_queue [$];

  function automatic face_shade_t shade_of_face();
    face_shade_t r;
    wide_t ax, ay, az, bx, by, bz, nx, ny, nz, dot, sq, root, c, q;
    ax = wide_t'(corner_x[1]) - wide_t'(corner_x[0]);
    ay = wide_t'(corner_y[1]) - wide_t'(corner_y[0]);
    az = wide_t'(corner_z[1]) - wide_t'(corner_z[0]);
    bx = wide_t'(corner_x[2]) - wide_t'(corner_x[0]);
    by = wide_t'(corner_y[2]) - wide_t'(corner_y[0]);
    bz = wide_t'(corner_z[2]) - wide_t'(corner_z[0]);
    nx = ay * bz - az * by;
    ny = az * bx - ax * bz;
    nz = ax * by - ay * bx;
    if (nx == 0 && ny == 0 && nz == 0) begin
      r.shade = '0;
      r.degenerate = 1'b1;
      return r;
    end
    dot = nx * wide_t'(light_x) + ny * wide_t'(light_y) + nz * wide_t'(light_z);
    if (dot < 0) dot = -dot;
    sq = nx * nx + ny * ny + nz * nz;
    // floor square root, one bit at a time
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (wide_t'(1) <<< b);
      if (c * c <= sq) root = c;
    end
    q = (dot * 255) / (root <<< LIGHT_FRAC_BITS);
    if (q > 255) q = 255;
    r.shade = q[SHADE_BITS-1:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    face_shade_t got, want;
    int errs;
    if (rst) begin
      corner_slot <= '0;
      light_x = LIGHT_X_RST;
      light_y = LIGHT_Y_RST;
      light_z = LIGHT_Z_RST;
      shade_queue.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      errs = 0;
      if (out_valid && out_ready) begin
        got.shade = shade;
        got.degenerate = degenerate;
        if (shade_queue.size() == 0) begin
          $error("result beat with no face waiting: shade %0d degenerate %0d",
                 shade, degenerate);
          errs++;
        end else begin
          want = shade_queue.pop_front();
          if (got.shade !== want.shade) begin
            $error("shade: expected %0d, actual %0d", want.shade, got.shade);
            errs++;
          end
          if (got.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, actual %0d", want.degenerate,
                   got.degenerate);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (cfg_we) begin
        case (cfg_index)
          REG_LIGHT_X: light_x = cfg_data;
          REG_LIGHT_Y: light_y = cfg_data;
          REG_LIGHT_Z: light_z = cfg_data;
          default: ;
        endcase
      end
      if (vert_valid && vert_ready) begin
        corner_x[corner_slot] = vert_x;
        corner_y[corner_slot] = vert_y;
        corner_z[corner_slot] = vert_z;
        if (corner_slot == SLOT_LAST) begin
          shade_queue.push_back(shade_of_face());
          corner_slot <= '0;
        end else begin
          corner_slot <= corner_slot + 2'd1;
        end
      end
      pending <= shade_queue.size();
    end
  end

endmodule

@@ bench/flat_face_shade_intensity_tb.sv @@
// testbench top for the flat face shading block: stimulus, stalls and verdict
`timescale 1ns / 1ps
module flat_face_shade_intensity_tb import ffsi_pkg::*;;

  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 600000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         vert_valid = 1'b0;
  logic                         vert_ready;
  logic signed [COORD_BITS-1:0] vert_x = '0, vert_y = '0, vert_z = '0;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_index = REG_LIGHT_X;
  logic [LIGHT_BITS-1:0]        cfg_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [SHADE_BITS-1:0]        shade;
  logic                         degenerate;
  int                           fail_count, pending;
  int                           cycles = 0;
  int                           burst_left = 0;
  int                           verts_sent = 0;
  int                           flat_faces = 0;
  int                           ready_pct = 100;

  localparam logic signed [COORD_BITS-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [COORD_BITS-1:0] CMIN = 24'sh800000;
  localparam logic signed [COORD_BITS-1:0] ONE  = 24'sh010000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flat_face_shade_intensity u_top (.*);

  ffsi_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: ready_pct = 100;
        2: ready_pct = 70;
        3: ready_pct = 30;
        default: ready_pct = 3;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) < ready_pct);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_vert(input logic signed [COORD_BITS-1:0] x, y, z);
    int gap;
    vert_x <= x;
    vert_y <= y;
    vert_z <= z;
    vert_valid <= 1'b1;
    @(posedge clk);
    while (!vert_ready) @(posedge clk);
    verts_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        vert_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every face has come back and the block has settled
  task automatic drain();
    vert_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_light(input logic [LIGHT_BITS-1:0] lx, ly, lz);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_LIGHT_X;
    cfg_data <= lx;
    @(posedge clk);
    cfg_index <= REG_LIGHT_Y;
    cfg_data <= ly;
    @(posedge clk);
    cfg_index <= REG_LIGHT_Z;
    cfg_data <= lz;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_face(input logic signed [COORD_BITS-1:0] x0, y0, z0, x1, y1, z1,
                           x2, y2, z2);
    send_vert(x0, y0, z0);
    send_vert(x1, y1, z1);
    send_vert(x2, y2, z2);
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord(input int mode);
    case (mode)
      0: return COORD_BITS'($urandom());
      1: return COORD_BITS'($signed($urandom_range(0, 2 * ONE)) - ONE);
      2: return COORD_BITS'($signed($urandom_range(0, 64)) - 32);
      default: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
    endcase
  endfunction

  function automatic logic [LIGHT_BITS-1:0] rand_light();
    return LIGHT_BITS'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic random_faces(input int count);
    logic signed [COORD_BITS-1:0] p [3][3];
    int mode, k;
    for (int f = 0; f < count; f++) begin
      mode = $urandom_range(0, 3);
      for (int v = 0; v < 3; v++)
        for (int a = 0; a < 3; a++) p[v][a] = rand_coord(mode);
      case ($urandom_range(0, 9))
        0: begin
          // collinear: third corner on the line of the first edge
          k = $signed($urandom_range(0, 6)) - 3;
          for (int a = 0; a < 3; a++) begin
            p[0][a] = rand_coord(1);
            p[1][a] = rand_coord(1);
            p[2][a] = COORD_BITS'(p[0][a] + k * (p[1][a] - p[0][a]));
          end
          flat_faces++;
        end
        1: begin
          p[$urandom_range(1, 2)] = p[0];
          flat_faces++;
        end
        default: ;
      endcase
      send_face(p[0][0], p[0][1], p[0][2], p[1][0], p[1][1], p[1][2],
                p[2][0], p[2][1], p[2][2]);
      if ($urandom_range(0, 40) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed faces under the reset light
    send_face('0, '0, '0, ONE, '0, '0, '0, ONE, '0);
    send_face(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX);
    send_face(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX);
    send_face(24'sd5, -24'sd7, 24'sd9, 24'sd5, -24'sd7, 24'sd9, 24'sd5, -24'sd7, 24'sd9);
    send_face('0, '0, '0, ONE, ONE, ONE, -ONE, -ONE, -ONE);
    flat_faces += 2;
    // zero light, saturating light, negative light, and an unused index
    set_light(16'sd0, 16'sd0, 16'sd0);
    send_face('0, '0, '0, ONE, '0, '0, '0, '0, ONE);
    set_light(16'sd16384, 16'sd16384, 16'sd16384);
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_face('0, '0, '0, ONE, -ONE, '0, ONE, ONE, ONE);
    set_light(-16'sd16384, -16'sd16384, -16'sd16384);
    send_face('0, '0, '0, '0, ONE, '0, ONE, '0, '0);

    // random faces across several light settings
    set_light(16'sd16384, 16'sd0, 16'sd0);
    random_faces(30);
    set_light(16'sd0, -16'sd16384, 16'sd0);
    random_faces(30);
    for (int ph = 0; ph < 4; ph++) begin
      set_light(rand_light(), rand_light(), rand_light());
      random_faces(25);
    end
    set_light(-16'sd7327, 16'sd0, 16'sd14654);
    random_faces(15);

    drain();
    $display("sent %0d vertices (%0d faces, %0d of them flat) over eleven light settings",
             verts_sent, verts_sent / 3, flat_faces);
    $display("receiver stalls varied from none to long; %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
